/* hw/rtl/bitmap_block_allocator_assert.svh */
// Assertion macros for the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bba_pkg.sv */
// Package with the allocator's types, constants, codes and helper functions.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF      = 16384;
    localparam int BLOCK_BYTES_DEF     = 4096;
    localparam int RESERVED_BLOCKS_DEF = 256;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int AADDR_W   = 26;
    localparam int CNT_W     = 15;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_cnt CNT_MAX       = '1;
    localparam t_cnt MANAGED_RESET = 15'd16384;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DFREE  = 2'd3;

    // Results of the word scan and modify unit.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] zero_bit;
        logic             bit_val;
    } t_word_res;

    function automatic t_cnt sat_inc(input t_cnt c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic t_cnt sat_dec(input t_cnt c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

endpackage

/* hw/rtl/bba_if.sv */
// Channel interfaces of the allocator: request, result and configuration.
interface bba_in_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] block_address;

    modport source(output valid, op, block_address, input ready);
    modport sink(input valid, op, block_address, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AADDR_W-1:0]  alloc_address;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    free_count;

    modport source(output valid, status, alloc_address, used_count, free_count, input ready);
    modport sink(input valid, status, alloc_address, used_count, free_count, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] managed_blocks;

    modport source(output valid, managed_blocks, input ready);
    modport sink(input valid, managed_blocks, output ready);
endinterface

/* hw/rtl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
//
//  Channel  Dir  Handshake           Payload
//  i_in     in   valid/ready         op, block_address
//  o_out    out  valid/ready         status, alloc_address, used_count, free_count
//  i_cfg    in   valid/ready         managed_blocks (always ready)
//
// Init sweeps the map: one map word is written per cycle.
// Alloc scans the managed part of the map: one map word is read and tested per cycle.
// Free shifts the address down to its block number, then reads the map word and clears
// the bit; an address out of range is answered without reading the map.
// After reset a clearing pass zeroes the map; no item is taken then.
// A result waits in the output register, so a stalled sink blocks nothing until the
// next item finishes.
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator import bba_pkg::*; #(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES     = BLOCK_BYTES_DEF,
    parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bba_in_if.sink    i_in,
    bba_out_if.source o_out,
    bba_cfg_if.sink   i_cfg
);

    // The map is kept as 32-bit words in a RAM.
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PTR_W     = $clog2(MAP_WORDS + 1);
    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int BLK_W     = $clog2(NUM_BLOCKS + 1);
    localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W    = (IDX_W + BB_W > AADDR_W) ? IDX_W + BB_W : AADDR_W;
    localparam int CMP_W     = 40;
    localparam logic [PTR_W-1:0] LAST_WORD = PTR_W'(MAP_WORDS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FCHK   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          r_state,  n_state;
    logic [PTR_W-1:0]    r_ptr,    n_ptr;
    logic [WA_W-1:0]     r_chk,    n_chk;
    logic                r_pend,   n_pend;
    logic [BLK_W-1:0]    r_k,      n_k;
    logic                r_report, n_report;
    t_cnt                r_used,   n_used;
    t_cnt                r_free,   n_free;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_aok,    n_aok;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic [WA_W-1:0]     r_fword,  n_fword;
    logic [BIT_W-1:0]    r_fbit,   n_fbit;
    t_cnt                r_managed;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [AADDR_W-1:0]  r_out_aaddr;
    t_cnt                r_out_used;
    t_cnt                r_out_free;

    logic            ram_we;
    logic [WA_W-1:0] ram_waddr;
    t_word           ram_wdata;
    logic            ram_re;
    logic [WA_W-1:0] ram_raddr;
    t_word           ram_rdata;

    t_word_res res;
    t_word     word_set;
    t_word     word_clr;

    logic              div_start;
    logic              div_done;
    logic [ADDR_W-1:0] div_quot;

    logic [BLK_W-1:0]  total;
    logic [BLK_W-1:0]  k_calc;
    logic              in_acc;
    logic              out_load;
    logic              issue;
    logic [CMP_W-1:0]  found_idx;
    logic [CMP_W-1:0]  sweep_base;
    logic [CMP_W-1:0]  fill_diff;
    logic [5:0]        fill_n;
    t_word             fill_word;
    logic [PROD_W-1:0] prod;

    // A managed count above the map size acts as the map size.
    assign total = (CMP_W'(r_managed) > CMP_W'(NUM_BLOCKS)) ?
                   BLK_W'(NUM_BLOCKS) : BLK_W'(r_managed);

    // Reserved blocks, or half the managed blocks when fewer are managed.
    assign k_calc = (CMP_W'(RESERVED_BLOCKS) > CMP_W'(total)) ?
                    (total >> 1) : BLK_W'(RESERVED_BLOCKS);

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);
    assign issue    = (CMP_W'({r_ptr, BIT_W'(0)}) < CMP_W'(total));
    assign found_idx = CMP_W'({r_chk, res.zero_bit});

    // Init fill pattern: bits below the reserved count are set.
    assign sweep_base = CMP_W'({r_ptr, BIT_W'(0)});
    assign fill_diff  = CMP_W'(r_k) - sweep_base;
    assign fill_n     = (CMP_W'(r_k) <= sweep_base) ? 6'd0 :
                        ((fill_diff >= CMP_W'(WORD_BITS)) ? 6'(WORD_BITS) : fill_diff[5:0]);
    assign fill_word  = ~({WORD_BITS{1'b1}} << fill_n);

    bba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_word_unit u_word (
        .i_word     (ram_rdata),
        .i_bit      (r_fbit),
        .o_res      (res),
        .o_word_set (word_set),
        .o_word_clr (word_clr)
    );

    assign div_start = in_acc && (i_in.op == OP_FREE);

    bba_div #(
        .DIVISOR(BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.block_address),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer: each state drives at most one map access per cycle.
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_chk     = r_chk;
        n_pend    = r_pend;
        n_k       = r_k;
        n_report  = r_report;
        n_used    = r_used;
        n_free    = r_free;
        n_status  = r_status;
        n_aok     = r_aok;
        n_idx     = r_idx;
        n_fword   = r_fword;
        n_fbit    = r_fbit;
        ram_we    = 1'b0;
        ram_waddr = r_ptr[WA_W-1:0];
        ram_wdata = fill_word;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[WA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_aok    = 1'b0;
                    case (i_in.op)
                        OP_INIT: begin
                            n_k      = k_calc;
                            n_used   = CNT_W'(k_calc);
                            n_free   = CNT_W'(total - k_calc);
                            n_ptr    = '0;
                            n_report = 1'b1;
                            n_state  = S_SWEEP;
                        end
                        OP_ALLOC: begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        OP_FREE: begin
                            n_state = S_DIV;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                ram_we = 1'b1;
                if (r_ptr == LAST_WORD) begin
                    n_state = r_report ? S_FINISH : S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SCAN: begin
                if (r_pend && res.found) begin
                    if (found_idx < CMP_W'(total)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_chk;
                        ram_wdata = word_set;
                        n_idx     = IDX_W'(found_idx);
                        n_aok     = 1'b1;
                        n_used    = sat_inc(r_used);
                        n_free    = sat_dec(r_free);
                    end else begin
                        n_status = ST_NOFREE;
                    end
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end else if (issue) begin
                    ram_re = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_chk  = r_ptr[WA_W-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_status = ST_NOFREE;
                    n_pend   = 1'b0;
                    n_state  = S_FINISH;
                end
            end
            S_DIV: begin
                ram_raddr = div_quot[BIT_W +: WA_W];
                if (div_done) begin
                    if (CMP_W'(div_quot) >= CMP_W'(total)) begin
                        n_status = ST_RANGE;
                        n_state  = S_FINISH;
                    end else begin
                        ram_re  = 1'b1;
                        n_fword = div_quot[BIT_W +: WA_W];
                        n_fbit  = div_quot[BIT_W-1:0];
                        n_state = S_FCHK;
                    end
                end
            end
            S_FCHK: begin
                if (!res.bit_val) begin
                    n_status = ST_DFREE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fword;
                    ram_wdata = word_clr;
                    n_used    = sat_dec(r_used);
                    n_free    = sat_inc(r_free);
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_k         <= '0;
            r_report    <= 1'b0;
            r_used      <= '0;
            r_free      <= '0;
            r_managed   <= MANAGED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_k      <= n_k;
            r_report <= n_report;
            r_used   <= n_used;
            r_free   <= n_free;
            if (i_cfg.valid && i_cfg.ready) begin
                r_managed <= i_cfg.managed_blocks;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Block number times block size; only a successful alloc reports it.
    assign prod = PROD_W'(r_idx) * PROD_W'(BLOCK_BYTES);

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_status <= n_status;
        r_aok    <= n_aok;
        r_idx    <= n_idx;
        r_fword  <= n_fword;
        r_fbit   <= n_fbit;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_aaddr  <= r_aok ? prod[AADDR_W-1:0] : '0;
            r_out_used   <= r_used;
            r_out_free   <= r_free;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.alloc_address = r_out_aaddr;
    assign o_out.used_count    = r_out_used;
    assign o_out.free_count    = r_out_free;

    // Map writes come only from the sweep after reset or init, the alloc hit or a valid free.
    `BBA_ASSERT_IMP(a_we_state, i_clk, i_rst_n, ram_we, (r_state == S_SWEEP) || (r_state == S_SCAN) || (r_state == S_FCHK), "map written outside a writing state")
    // Every accepted item leaves the idle state on the next cycle.
    `BBA_ASSERT_NXT(a_acc_leaves, i_clk, i_rst_n, in_acc, r_state != S_IDLE, "accepted item did not start")
    // The block number is only produced for a free request.
    `BBA_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_done, r_state == S_DIV, "divider active outside free")
    // A finished item is presented on the result port in the next cycle.
    `BBA_ASSERT_NXT(a_out_loaded, i_clk, i_rst_n, out_load, r_out_valid && (r_state == S_IDLE), "result not presented")

endmodule

/* hw/rtl/bba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bba_word_unit.sv */
// Shared map-word unit: finds the lowest free bit and sets or clears one bit.
module bba_word_unit import bba_pkg::*; (
    input  t_word            i_word,
    input  logic [BIT_W-1:0] i_bit,
    output t_word_res        o_res,
    output t_word            o_word_set,
    output t_word            o_word_clr
);

    logic [BIT_W-1:0] zero_bit;
    logic             found;

    // Priority encoder over the clear bits, lowest index wins.
    always_comb begin
        zero_bit = '0;
        found    = 1'b0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                zero_bit = BIT_W'(b);
                found    = 1'b1;
            end
        end
    end

    assign o_res.found    = found;
    assign o_res.zero_bit = zero_bit;
    assign o_res.bit_val  = i_word[i_bit];
    assign o_word_set     = i_word | (t_word'(1) << zero_bit);
    assign o_word_clr     = i_word & ~(t_word'(1) << i_bit);

endmodule

/* hw/rtl/bba_div.sv */
// Block-number unit: turns a byte address into a block number with one shift.
module bba_div import bba_pkg::*; #(
    parameter int DIVISOR = BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quot
);

    // Block size must be a power of two (unchecked); quotient = address shifted down.
    localparam int SHIFT = $clog2(DIVISOR);

    logic [ADDR_W-1:0] r_q;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend >> SHIFT;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the bitmap block allocator, with directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // The block ignores op 3; the package gives it no name.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    // A clean run never goes this long without a handshake. The worst case is the
    // clearing pass after reset, then an init, then a full alloc scan with the
    // result stalled.
    localparam int QUIET_LIMIT  = 5000;
    // The longest single operation is a full alloc scan.
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AADDR_W-1:0]  alloc_address;
        t_cnt                used_count;
        t_cnt                free_count;
    } t_alloc_result;

    typedef struct {
        int managed;
        bit start_init;
        int items;
    } t_phase;

    // Mirror of the allocator. It holds the used map, the two counters and the
    // managed count, and it keeps the results owed for accepted requests in order.
    class alloc_scoreboard;
        bit            block_used [NUM_BLOCKS_DEF];
        t_cnt          used_total;
        t_cnt          free_total;
        t_cnt          managed;
        t_alloc_result expected_results [$];
        int            error_count;
        int            request_count;
        int            status_seen [4];

        function new();
            managed       = MANAGED_RESET;
            used_total    = '0;
            free_total    = '0;
            error_count   = 0;
            request_count = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // A managed count above the map size acts as the map size.
        function int managed_limit();
            return (managed > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(managed);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
            t_alloc_result r;
            int            total;
            int            k;
            logic [31:0]   blk;
            total = managed_limit();
            r     = '0;
            request_count++;
            case (op)
                OP_INIT: begin
                    k = RESERVED_BLOCKS_DEF;
                    if (k > total) k = total / 2;
                    foreach (block_used[i]) block_used[i] = (i < k);
                    used_total = t_cnt'(k);
                    free_total = t_cnt'(total - k);
                end
                OP_ALLOC: begin
                    r.status = ST_NOFREE;
                    for (int i = 0; i < total; i++) begin
                        if (!block_used[i]) begin
                            block_used[i]   = 1'b1;
                            used_total      = sat_up(used_total);
                            free_total      = sat_down(free_total);
                            r.alloc_address = AADDR_W'(i * BLOCK_BYTES_DEF);
                            r.status        = ST_OK;
                            break;
                        end
                    end
                end
                OP_FREE: begin
                    blk = addr / ADDR_W'(BLOCK_BYTES_DEF);
                    if (blk >= total) begin
                        r.status = ST_RANGE;
                    end else if (!block_used[blk]) begin
                        r.status = ST_DFREE;
                    end else begin
                        block_used[blk] = 1'b0;
                        used_total      = sat_down(used_total);
                        free_total      = sat_up(free_total);
                    end
                end
                default: begin
                end
            endcase
            r.used_count = used_total;
            r.free_count = free_total;
            status_seen[r.status]++;
            expected_results.push_back(r);
        endfunction

        function t_cnt sat_up(t_cnt c);
            return (c == CNT_MAX) ? c : c + 1'b1;
        endfunction

        function t_cnt sat_down(t_cnt c);
            return (c == '0) ? c : c - 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d addr %0h",
                         $time, got.status, got.alloc_address);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("alloc_address", want.alloc_address, got.alloc_address);
            compare_field("used_count", want.used_count, got.used_count);
            compare_field("free_count", want.free_count, got.free_count);
        endfunction

        // Finds a used block below the managed count. Most searches start low so
        // that recently allocated blocks get freed, not only the reserved ones.
        function bit find_used(output int blk);
            int total;
            int start;
            int i;
            total = managed_limit();
            blk   = 0;
            if (total == 0) return 1'b0;
            if ($urandom_range(3) != 0) begin
                start = $urandom_range(((total < 400) ? total : 400) - 1);
            end else begin
                start = $urandom_range(total - 1);
            end
            for (int n = 0; n < total; n++) begin
                i = (start + n) % total;
                if (block_used[i]) begin
                    blk = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bba_in_if  req_ch ();
    bba_out_if res_ch ();
    bba_cfg_if cfg_ch ();

    bitmap_block_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    alloc_scoreboard board = new();

    // Idle rates in percent, changed between phases of the run. The directed part
    // runs with the sender rarely idle and the receiver mostly idle.
    int send_idle_pct = 15;
    int recv_idle_pct = 61;
    int settings_written = 0;

    // Each phase sets the managed count, optionally starts with an init, and then
    // sends random traffic. The list holds the extremes of the register, the edge
    // around the reserved count, and one phase that widens the range without an
    // init so that the stale free count runs down to zero and saturates.
    t_phase phases [13] = '{
        '{16384, 1'b1, 40},
        '{8,     1'b1, 35},
        '{16384, 1'b0, 20},
        '{40,    1'b1, 40},
        '{32767, 1'b1, 40},
        '{1,     1'b1, 20},
        '{300,   1'b1, 35},
        '{0,     1'b1, 15},
        '{3,     1'b1, 30},
        '{600,   1'b1, 40},
        '{256,   1'b1, 30},
        '{257,   1'b1, 40},
        '{16384, 1'b1, 35}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random. Ready changes only at the falling edge.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result accepted at a rising edge is checked against the oldest
    // expectation.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                board.check_result({res_ch.status, res_ch.alloc_address,
                                    res_ch.used_count, res_ch.free_count});
            end
        end
    end

    // The watchdog counts cycles with no handshake on any channel.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog, no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] address_in_block(int blk, logic [ADDR_W-1:0] noise);
        return ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES_DEF) + noise % ADDR_W'(BLOCK_BYTES_DEF);
    endfunction

    // Presents one request from the next falling edge, after a random gap, and
    // holds it until the block takes it. Valid is left high; the next call either
    // replaces the item or lowers valid at the following falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.block_address <= addr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(op, addr);
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes the managed count. Called only while the block is idle.
    task automatic write_managed(input t_cnt value);
        @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.managed_blocks <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.managed = value;
        settings_written++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly allocs and frees of blocks that are in use, with some inits, ignored
    // ops, double frees and addresses past the managed range mixed in.
    task automatic send_random_request();
        int                pick;
        int                total;
        int                blk;
        logic [ADDR_W-1:0] noise;
        pick  = $urandom_range(99);
        total = board.managed_limit();
        noise = $urandom();
        if (pick < 3) begin
            send_request(OP_INIT, noise);
        end else if (pick < 5) begin
            send_request(OP_IGNORED, noise);
        end else if (pick < 50) begin
            send_request(OP_ALLOC, noise);
        end else if (pick < 80 && board.find_used(blk)) begin
            send_request(OP_FREE, address_in_block(blk, noise));
        end else if (pick < 88) begin
            send_request(OP_FREE, address_in_block($urandom_range(total + 2), noise));
        end else if (pick < 94 || total == 0) begin
            send_request(OP_FREE, noise);
        end else begin
            send_request(OP_FREE, address_in_block($urandom_range(total - 1), noise));
        end
    endtask

    initial begin
        req_ch.valid          = 1'b0;
        req_ch.op             = OP_INIT;
        req_ch.block_address  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.managed_blocks = MANAGED_RESET;
        i_rst_n               = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset managed count. The first alloc comes before
        // any init, so the free count is already zero and must stay there.
        send_request(OP_ALLOC, '0);
        send_request(OP_IGNORED, '1);
        send_request(OP_INIT, '1);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        // An unaligned address frees its block; the same block again is a double free.
        send_request(OP_FREE, address_in_block(RESERVED_BLOCKS_DEF, '1));
        send_request(OP_FREE, address_in_block(RESERVED_BLOCKS_DEF, '0));
        send_request(OP_FREE, '1);
        send_request(OP_FREE, address_in_block(NUM_BLOCKS_DEF, '0));
        send_request(OP_FREE, address_in_block(NUM_BLOCKS_DEF - 1, '1));
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_IGNORED, '0);

        // With two blocks only one is reserved, so the second alloc finds none free.
        wait_drained();
        write_managed(t_cnt'(2));
        send_request(OP_INIT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, address_in_block(1, 5));
        send_request(OP_FREE, address_in_block(2, 0));
        send_request(OP_FREE, address_in_block(1, 0));

        // With nothing managed every alloc and every free is refused.
        wait_drained();
        write_managed(t_cnt'(0));
        send_request(OP_INIT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);

        // Random part. The first third of the phases stalls the result side
        // heavily, the second third starves the request side, the rest runs flat out.
        for (int p = 0; p < $size(phases); p++) begin
            case (p * 3 / $size(phases))
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_drained();
            write_managed(t_cnt'(phases[p].managed));
            if (phases[p].start_init) send_request(OP_INIT, $urandom());
            for (int n = 0; n < phases[p].items; n++) begin
                // Now and then the request side waits for the block to drain.
                if ($urandom_range(29) == 0) wait_drained();
                send_random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests under %0d managed-count settings, from none to the full map.",
                 board.request_count, settings_written);
        $display("Result mix: %0d ok, %0d none free, %0d out of range, %0d double free.",
                 board.status_seen[ST_OK], board.status_seen[ST_NOFREE],
                 board.status_seen[ST_RANGE], board.status_seen[ST_DFREE]);
        if (board.error_count == 0 && board.expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_word_unit.sv
hw/rtl/bba_div.sv
hw/rtl/bitmap_block_allocator.sv
tb/tb.sv
